/* hw/rtl/mcdl_pkg.sv */
// Shared types, constants and month tables for the month calendar day layout block.
package mcdl_pkg;

  localparam int YearW  = 14;
  localparam int MulBW  = 16;
  localparam int ProdW  = YearW + MulBW;

  // Reciprocal constants: x/100 ~ (x*5243)>>19, x/7 ~ (x*37450)>>18 over 14-bit x
  localparam logic [MulBW-1:0] Recip100 = 16'd5243;
  localparam logic [MulBW-1:0] Recip7   = 16'd37450;
  localparam int Div100Shift = 19;
  localparam int Div400Shift = 21;
  localparam int Div7Shift   = 18;
  localparam int Q100W       = 7;
  localparam int Q400W       = 5;
  localparam int Q7W         = 11;

  localparam logic [YearW-1:0] YearGreg   = 14'd1800;
  localparam logic [YearW-1:0] YearCent   = 14'd1701;
  localparam logic [YearW-1:0] YearQuad   = 14'd1601;
  localparam logic [YearW-1:0] YearShift  = 14'd1752;
  localparam logic [YearW-1:0] YearMax    = 14'd9999;

  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthMax = 4'd12;

  localparam logic [4:0] FebShortLen = 5'd28;
  localparam logic [4:0] SepGapStart = 5'd2;
  localparam logic [4:0] SepGapEnd   = 5'd14;

  typedef struct packed {
    logic [3:0]       month;
    logic [YearW-1:0] year;
  } in_item_t;

  typedef struct packed {
    logic [4:0] day_number;
    logic [2:0] week_row;
    logic [2:0] weekday_column;
    logic       last_day;
    logic       bad_input;
  } out_item_t;

  typedef struct packed {
    logic [YearW-1:0] a;
    logic [MulBW-1:0] b;
  } mul_req_t;

  // Month length, February taken as 29
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                         len = 5'd29;
      4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
      default:                      len = 5'd31;
    endcase
    return len;
  endfunction

  // Days before month m in a common year, mod 7
  function automatic logic [2:0] cum_mod7(input logic [3:0] m);
    logic [2:0] c;
    case (m)
      4'd2:    c = 3'd3;
      4'd3:    c = 3'd3;
      4'd4:    c = 3'd6;
      4'd5:    c = 3'd1;
      4'd6:    c = 3'd4;
      4'd7:    c = 3'd6;
      4'd8:    c = 3'd2;
      4'd9:    c = 3'd5;
      4'd10:   c = 3'd0;
      4'd11:   c = 3'd3;
      4'd12:   c = 3'd5;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  // Reduce a value below 21 mod 7
  function automatic logic [2:0] mod7_small(input logic [4:0] v);
    logic [4:0] r;
    if (v >= 5'd14) begin
      r = v - 5'd14;
    end else if (v >= 5'd7) begin
      r = v - 5'd7;
    end else begin
      r = v;
    end
    return r[2:0];
  endfunction

endpackage

/* hw/rtl/mcdl_mul.sv */
// Shared registered multiplier used by the weekday sequencer.
module mcdl_mul (
  input  logic                            clk,
  input  mcdl_pkg::mul_req_t              req,
  output logic [mcdl_pkg::ProdW-1:0]      prod
);
  import mcdl_pkg::*;

  always_ff @(posedge clk) begin
    prod <= ProdW'(req.a) * ProdW'(req.b);
  end

endmodule

/* hw/rtl/mcdl_seq.sv */
// Sequencer: weekday setup on shared multiplier, then one day per cycle while out_ready.
module mcdl_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mcdl_pkg::in_item_t          in_data,
  output mcdl_pkg::mul_req_t          mul_req,
  input  logic [mcdl_pkg::ProdW-1:0]  prod,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mcdl_pkg::out_item_t         out_data
);
  import mcdl_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ERR  = 4'd1;
  localparam logic [3:0] S_MA   = 4'd2;
  localparam logic [3:0] S_MB   = 4'd3;
  localparam logic [3:0] S_MC   = 4'd4;
  localparam logic [3:0] S_MD   = 4'd5;
  localparam logic [3:0] S_ME   = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0]       state;
  logic [3:0]       month;
  logic [YearW-1:0] year;
  logic [YearW-1:0] yy;
  logic             pass;
  logic [Q100W-1:0] q100;
  logic [YearW-1:0] d;
  logic [2:0]       w0;
  logic [4:0]       day;
  logic [2:0]       row;
  logic [2:0]       col;
  logic [4:0]       last_num;
  logic             short_sep;

  logic             in_bad;
  logic             slot_free;
  logic             emit;
  logic [YearW-1:0] d_calc;
  logic [Q400W-1:0] q400;
  logic [Q7W-1:0]   q7;
  logic [YearW-1:0] rem_calc;
  logic [2:0]       diff;
  logic             feb28;
  logic             sep_short_yr;
  logic [4:0]       col_sum;
  logic [2:0]       col0;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign emit      = slot_free && ((state == S_ERR) || (state == S_EMIT));
  assign in_bad    = (in_data.month == 4'd0) || (in_data.month > MonthMax) ||
                     (in_data.year == '0) || (in_data.year > YearMax);

  // Operand select for the shared multiplier
  always_comb begin
    mul_req.a = '0;
    mul_req.b = Recip100;
    case (state)
      S_MA: begin
        if (yy > YearGreg) mul_req.a = yy - YearCent;
      end
      S_MB: begin
        if (yy > YearGreg) mul_req.a = yy - YearQuad;
      end
      S_MD, S_ME: begin
        mul_req.a = d;
        mul_req.b = Recip7;
      end
      default: begin
        mul_req.a = '0;
      end
    endcase
  end

  assign q400   = prod[Div400Shift +: Q400W];
  assign d_calc = YearW'((YearW+1)'(yy) + (((YearW+1)'(yy) + 15'd3) >> 2) + 15'd4 +
                         (YearW+1)'(q400) + ((yy > YearShift) ? 15'd3 : 15'd0) -
                         (YearW+1)'(q100));
  assign q7       = prod[Div7Shift +: Q7W];
  assign rem_calc = d - YearW'({q7, 3'b000}) + YearW'(q7);

  // Year-length decode from the weekday step between consecutive years
  assign diff         = mod7_small(5'(rem_calc[2:0]) + 5'd7 - 5'(w0));
  assign feb28        = (diff == 3'd1);
  assign sep_short_yr = (diff != 3'd1) && (diff != 3'd2);
  assign col_sum      = 5'(w0) + 5'(cum_mod7(month)) +
                        (((month > MonthFeb) && !feb28) ? 5'd1 : 5'd0) +
                        ((sep_short_yr && (month > MonthSep)) ? 5'd3 : 5'd0);
  assign col0         = mod7_small(col_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            month <= in_data.month;
            year  <= in_data.year;
            yy    <= in_data.year;
            pass  <= 1'b0;
            state <= in_bad ? S_ERR : S_MA;
          end
        end
        S_ERR: begin
          if (slot_free) begin
            out_data  <= '{day_number: 5'd0, week_row: 3'd0, weekday_column: 3'd0,
                           last_day: 1'b1, bad_input: 1'b1};
            state     <= S_IDLE;
          end
        end
        S_MA: state <= S_MB;
        S_MB: begin
          q100  <= prod[Div100Shift +: Q100W];
          state <= S_MC;
        end
        S_MC: begin
          d     <= d_calc;
          state <= S_MD;
        end
        S_MD: state <= S_ME;
        S_ME: begin
          if (!pass) begin
            w0    <= rem_calc[2:0];
            yy    <= YearW'(year + 14'd1);
            pass  <= 1'b1;
            state <= S_MA;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          day       <= 5'd1;
          row       <= 3'd0;
          col       <= col0;
          short_sep <= sep_short_yr && (month == MonthSep);
          last_num  <= ((month == MonthFeb) && feb28) ? FebShortLen : month_len(month);
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_data  <= '{day_number: day, week_row: row, weekday_column: col,
                           last_day: (day == last_num), bad_input: 1'b0};
            day       <= (short_sep && (day == SepGapStart)) ? SepGapEnd : day + 5'd1;
            if (col == 3'd6) begin
              col <= 3'd0;
              row <= row + 3'd1;
            end else begin
              col <= col + 3'd1;
            end
            if (day == last_num) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/month_calendar_day_layout_top.sv */
// Top level of the month calendar day layout block.
// Takes one request (month, year) and returns the printed days of that month, one result
// per day in order, each with its calendar row, weekday column (0 Sunday) and a last flag
// on the final one. The weekday of January 1 follows the old calendar rule: a Julian count,
// a Gregorian correction for years after 1800 and a three-day shift after 1752; September
// 1752 prints days 1, 2 and 14 to 30. A month outside 1..12 or a year outside 1..9999
// returns a single result with bad_input and last_day set and all else zero.
// Timing: after acceptance a valid request runs through setup (five multiplier steps
// for each of two years plus one decode step), then emits one day per cycle while
// out_ready stays high. The setup runs through the single shared 14x16 multiplier,
// used for the divisions by 100, 400 and 7. An error request is accepted, then its
// result is loaded once the output register is free. in_ready is high only between
// requests; the last result may still sit in the output register when the next request
// is accepted.
module month_calendar_day_layout_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mcdl_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mcdl_pkg::out_item_t  out_data
);
  import mcdl_pkg::*;

  mul_req_t         mul_req;
  logic [ProdW-1:0] prod;

  // Shared multiplier: operands from the sequencer, registered product back in the next cycle
  mcdl_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // Sequencer: range check, weekday setup, per-day result generation and output register
  mcdl_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .mul_req   (mul_req),
    .prod      (prod),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/mcdl_checker.sv */
// Port-level checker for the month calendar day layout block, with its bind.
module mcdl_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input mcdl_pkg::in_item_t   in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input mcdl_pkg::out_item_t  out_data
);
  import mcdl_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Busy after taking a request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // Error result shape
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bad_input |->
      out_data.last_day && (out_data.day_number == 5'd0) &&
      (out_data.week_row == 3'd0) && (out_data.weekday_column == 3'd0))
    else $error("malformed error result");

  // Day results stay in range
  a_day: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.bad_input |->
      (out_data.day_number != 5'd0) && (out_data.weekday_column < 3'd7) &&
      (out_data.week_row < 3'd6))
    else $error("day result out of range");

  // A run continues without gaps while the consumer keeps taking
  a_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_day |=> out_valid)
    else $error("gap inside a month run");

endmodule

bind month_calendar_day_layout_top mcdl_checker u_chk (.*);
